@@ rtl/diag_message_can_segmenter_macros.svh @@
// assertion macros used by the segmenter framer
`ifndef DIAG_MESSAGE_CAN_SEGMENTER_MACROS_SVH
`define DIAG_MESSAGE_CAN_SEGMENTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DMCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segmenter assertion failed");

// next-cycle implication, disabled during reset
`define DMCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segmenter assertion failed");

`endif

@@ rtl/dmcs_pkg.sv @@
// shared constants and types of the diagnostic message segmenter
`default_nettype none
package dmcs_pkg;
   localparam int BYTE_W            = 8;
   localparam int COUNT_W           = 3;
   localparam int PAYLOAD_PER_FRAME = 7;
   localparam int FRAME_SLOTS       = 7;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam byte_type LONE_BASE   = 8'hC8;
   localparam byte_type LAST_BASE   = 8'h48;
   localparam byte_type SERIES_BASE = 8'h08;

   typedef struct packed {
      byte_type msg_byte;
      logic     end_of_message;
   } dmcs_item_type;
endpackage
`default_nettype wire

@@ rtl/dmcs_req_if.sv @@
// request channel: one message byte per word
`default_nettype none
interface dmcs_req_if;
   logic              valid;
   logic              ready;
   dmcs_pkg::byte_type msg_byte;
   logic              end_of_message;

   modport source (output valid, output msg_byte, output end_of_message, input ready);
   modport sink   (input valid, input msg_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

@@ rtl/dmcs_rsp_if.sv @@
// response channel: one can frame per word
`default_nettype none
interface dmcs_rsp_if;
   logic               valid;
   logic               ready;
   dmcs_pkg::byte_type prefix_byte;
   dmcs_pkg::byte_type payload_0;
   dmcs_pkg::byte_type payload_1;
   dmcs_pkg::byte_type payload_2;
   dmcs_pkg::byte_type payload_3;
   dmcs_pkg::byte_type payload_4;
   dmcs_pkg::byte_type payload_5;
   dmcs_pkg::byte_type payload_6;
   logic               final_frame;

   modport source (output valid, output prefix_byte, output payload_0, output payload_1,
                   output payload_2, output payload_3, output payload_4, output payload_5,
                   output payload_6, output final_frame, input ready);
   modport sink   (input valid, input prefix_byte, input payload_0, input payload_1,
                   input payload_2, input payload_3, input payload_4, input payload_5,
                   input payload_6, input final_frame, output ready);
endinterface
`default_nettype wire

@@ rtl/dmcs_in_stage.sv @@
// input register of the segmenter
`default_nettype none
module dmcs_in_stage (
   input  wire logic           clock,
   input  wire logic           reset,
   dmcs_req_if.sink            req_chan,
   input  wire logic           s1_take,
   output logic                s1_valid,
   output dmcs_pkg::dmcs_item_type s1_item
);
   import dmcs_pkg::*;

   logic          valid_ff, valid_in;
   dmcs_item_type item_ff;
   logic          load;

   assign req_chan.ready = !valid_ff || s1_take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (s1_take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.msg_byte       <= req_chan.msg_byte;
         item_ff.end_of_message <= req_chan.end_of_message;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;
endmodule
`default_nettype wire

@@ rtl/dmcs_framer.sv @@
// frame buffer, prefix choice and frame output register
`default_nettype none
`include "diag_message_can_segmenter_macros.svh"
module dmcs_framer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                s1_valid,
   input  wire dmcs_pkg::dmcs_item_type s1_item,
   output logic                     s1_take,
   dmcs_rsp_if.source               rsp_chan
);
   import dmcs_pkg::*;

   byte_type  frame_bytes_ff [FRAME_SLOTS];
   count_type fill_count_ff, fill_count_in;
   count_type frame_index_ff, frame_index_in;
   logic      sent_ff, sent_in;
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  prefix_ff, prefix_in;
   byte_type  payload_ff [FRAME_SLOTS];
   byte_type  payload_in [FRAME_SLOTS];
   logic      final_ff;

   count_type pos;
   count_type n;
   count_type next_index;
   logic      last;
   logic      produce;
   logic      out_free;
   logic      emit;

   assign pos        = fill_count_ff;
   assign n          = count_type'(fill_count_ff + 3'd1);
   assign next_index = count_type'(frame_index_ff + 3'd1);
   assign last       = s1_item.end_of_message;
   assign produce    = last || (n == count_type'(PAYLOAD_PER_FRAME));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_take    = s1_valid && (!produce || out_free);
   assign emit       = s1_take && produce;

   // current byte bypasses the buffer, unused slots read zero
   always_comb begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
         if (count_type'(j) == pos) begin
            payload_in[j] = s1_item.msg_byte;
         end else if (count_type'(j) < pos) begin
            payload_in[j] = frame_bytes_ff[j];
         end else begin
            payload_in[j] = '0;
         end
      end
   end

   always_comb begin
      if (last) begin
         prefix_in = (sent_ff ? LAST_BASE : LONE_BASE) + byte_type'(n);
      end else begin
         prefix_in = SERIES_BASE + byte_type'(next_index);
      end
   end

   always_comb begin
      fill_count_in  = fill_count_ff;
      frame_index_in = frame_index_ff;
      sent_in        = sent_ff;
      if (s1_take) begin
         if (!produce) begin
            fill_count_in = n;
         end else if (last) begin
            fill_count_in  = '0;
            frame_index_in = '0;
            sent_in        = 1'b0;
         end else begin
            fill_count_in  = '0;
            frame_index_in = next_index;
            sent_in        = 1'b1;
         end
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff  <= '0;
         frame_index_ff <= '0;
         sent_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fill_count_ff  <= fill_count_in;
         frame_index_ff <= frame_index_in;
         sent_ff        <= sent_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
         if (s1_take && count_type'(j) == pos) begin
            frame_bytes_ff[j] <= s1_item.msg_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         prefix_ff  <= prefix_in;
         payload_ff <= payload_in;
         final_ff   <= last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prefix_byte = prefix_ff;
   assign rsp_chan.payload_0   = payload_ff[0];
   assign rsp_chan.payload_1   = payload_ff[1];
   assign rsp_chan.payload_2   = payload_ff[2];
   assign rsp_chan.payload_3   = payload_ff[3];
   assign rsp_chan.payload_4   = payload_ff[4];
   assign rsp_chan.payload_5   = payload_ff[5];
   assign rsp_chan.payload_6   = payload_ff[6];
   assign rsp_chan.final_frame = final_ff;

   `DMCS_ASSERT_NOW(a_fill_range, clock, reset, 1'b1,
                    fill_count_ff < count_type'(PAYLOAD_PER_FRAME))
   `DMCS_ASSERT_NEXT(a_final_clears, clock, reset, emit && last,
                     frame_index_ff == '0 && !sent_ff && fill_count_ff == '0)
   `DMCS_ASSERT_NEXT(a_series_marks_sent, clock, reset, emit && !last,
                     sent_ff && rsp_valid_ff && !final_ff)
   `DMCS_ASSERT_NOW(a_no_take_when_blocked, clock, reset,
                    s1_valid && produce && rsp_valid_ff && !rsp_chan.ready, !s1_take)
endmodule
`default_nettype wire

@@ rtl/diag_message_can_segmenter.sv @@
// top level of the diagnostic message can segmenter
// usage:
//  - req_chan carries one message byte per word: the ecu id first, then request id and
//    parameter bytes; end_of_message marks the final byte of the message
//  - rsp_chan carries one can frame per word: prefix byte, seven payload bytes (zero when
//    unused) and final_frame
//  - a frame goes out when seven bytes are held or the message ends; a lone frame gets
//    0xc8 plus its length, the closing frame of a longer message 0x48 plus its length,
//    any other frame the series id 8 + ((index + 1) mod 8)
//  - one byte is taken every cycle while the framer is not blocked; the byte that completes a
//    frame passes the input register, then the frame register, before the frame appears
//  - the input register and the frame register decouple the two sides, so a byte that
//    only fills the buffer moves on even while a frame waits to be taken
//  - when the receiver stalls, the frame holds; a byte that would complete the next frame
//    waits in the input register and req ready drops until the frame is taken
//  - reset clears the fill count, frame index and valid flags; no clearing pass is needed
//    as buffer entries are only read after being written in the current frame
`default_nettype none
module diag_message_can_segmenter (
   input  wire logic   clock,
   input  wire logic   reset,
   dmcs_req_if.sink    req_chan,
   dmcs_rsp_if.source  rsp_chan
);
   import dmcs_pkg::*;

   // input register to framer handoff
   logic          s1_valid;
   logic          s1_take;
   dmcs_item_type s1_item;

   dmcs_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .s1_take  (s1_take),
      .s1_valid (s1_valid),
      .s1_item  (s1_item)
   );

   // buffer, prefix selection and frame register
   dmcs_framer u_framer (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_item  (s1_item),
      .s1_take  (s1_take),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire
